[hdl/pis_pkg.sv]
// Shared types and constants for the pulsed irrigation sequencer.
package pis_pkg;

  localparam int unsigned DIVIDEND_W = 21;
  localparam int unsigned DIVISOR_W  = 4;
  localparam int unsigned CNT_W      = $clog2(DIVIDEND_W + 1);

  typedef enum logic [2:0] {
    MODE_MONITOR = 3'd0,
    MODE_WATER   = 3'd1,
    MODE_SOAK    = 3'd2,
    MODE_COOL    = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_ACTIVE    = 3'd0,
    REG_PER_PLANT = 3'd1,
    REG_BASE      = 3'd2,
    REG_SOAK_CYC  = 3'd3,
    REG_SOAK_MS   = 3'd4,
    REG_COOL_MS   = 3'd5,
    REG_TICK_MS   = 3'd6,
    REG_NONE      = 3'd7
  } reg_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/pis_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module pis_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pis_pkg::div_req_t req_i,
  output pis_pkg::div_rsp_t rsp_o
);
  import pis_pkg::*;

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        cnt_q  <= CNT_W'(DIVIDEND_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
        quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hdl/pulsed_irrigation_sequencer_top.sv]
// Top level of the pulsed irrigation sequencer: registers, sequencer and result beat.
//
// Each input beat is one control tick and yields exactly one result beat. The tick is
// latched and the elapsed timer updated at the accepting edge. Then the serial divider
// forms the pulse length (one quotient bit per cycle), the quotient is latched, the
// sequencer checks that the result register is free, and it steps the pump sequence
// through the shared timer compare. in_stall_o stays high meanwhile, so the next tick
// is taken at the earliest in the cycle in which the result appears; a new tick is
// not taken before the last one is through. A tick whose quotient is ready waits in
// the sequencer, with in_stall_o still high, while the previous result waits on
// out_stall_i. The configuration port takes writes at any time but expects them
// only between ticks.
module pulsed_irrigation_sequencer_top #(
  parameter int unsigned MAX_PLANTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  dry_flags_i,
  input  logic [7:0]  fault_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  display_mode_o,
  output logic        pump_on_o,
  output logic [7:0]  needs_water_o,
  output logic [3:0]  pulses_left_o
);
  import pis_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_UPD
  } state_e;

  logic [3:0]  active_q;
  logic [15:0] per_plant_q;
  logic [15:0] base_q;
  logic [3:0]  soak_cyc_q;
  logic [23:0] soak_ms_q;
  logic [23:0] cool_ms_q;
  logic [15:0] tick_ms_q;

  state_e      state_q;
  logic        pump_q;
  logic [3:0]  soaks_q;
  logic        cool_q;
  logic [31:0] elapsed_q;
  logic        all_fault_q;
  logic        any_dry_q;
  logic [7:0]  dry_q;
  logic [DIVIDEND_W-1:0] pulse_q;

  logic        out_valid_q;
  mode_e       mode_q;
  logic        pump_out_q;
  logic [7:0]  needs_q;
  logic [3:0]  pulses_q;

  reg_e        wr_idx;
  logic        wr_en;
  logic        accept;

  logic [5:0]  n_wide;
  logic [3:0]  n_eff;
  logic [15:0] mask16;
  logic [7:0]  mask8;
  logic [3:0]  soaks_eff;
  logic [19:0] prod;
  logic [32:0] sum;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [31:0] thr;
  logic        ge;
  mode_e       mode_d;
  logic        pump_d;
  logic [3:0]  soaks_d;
  logic        cool_d;
  logic [31:0] elapsed_d;
  logic [3:0]  soaks_dec;

  assign pready = 1'b1;
  assign wr_idx = reg_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    unique case (wr_idx)
      REG_ACTIVE:    prdata = {28'd0, active_q};
      REG_PER_PLANT: prdata = {16'd0, per_plant_q};
      REG_BASE:      prdata = {16'd0, base_q};
      REG_SOAK_CYC:  prdata = {28'd0, soak_cyc_q};
      REG_SOAK_MS:   prdata = {8'd0, soak_ms_q};
      REG_COOL_MS:   prdata = {8'd0, cool_ms_q};
      REG_TICK_MS:   prdata = {16'd0, tick_ms_q};
      default:       prdata = '0;
    endcase
  end

  assign n_wide    = ({2'b00, active_q} > 6'(MAX_PLANTS)) ? 6'(MAX_PLANTS)
                                                          : {2'b00, active_q};
  assign n_eff     = n_wide[3:0];
  assign mask16    = (16'd1 << n_eff) - 16'd1;
  assign mask8     = mask16[7:0];
  assign soaks_eff = (soak_cyc_q == 4'd0) ? 4'd1 : soak_cyc_q;
  assign prod      = 20'(per_plant_q) * 20'(n_eff);
  assign sum       = {1'b0, elapsed_q} + {17'd0, tick_ms_q};

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign div_req.start    = accept;
  assign div_req.dividend = {1'b0, prod} + DIVIDEND_W'(base_q);
  assign div_req.divisor  = soaks_eff;

  pis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    priority if (pump_q) begin
      thr = 32'(pulse_q);
    end else if (soaks_q != 4'd0) begin
      thr = {8'd0, soak_ms_q};
    end else begin
      thr = {8'd0, cool_ms_q};
    end
  end

  assign ge        = elapsed_q >= thr;
  assign soaks_dec = (soaks_q != 4'd0) ? soaks_q - 4'd1 : 4'd0;

  always_comb begin
    pump_d    = pump_q;
    soaks_d   = soaks_q;
    cool_d    = cool_q;
    elapsed_d = elapsed_q;
    mode_d    = MODE_MONITOR;
    priority if (pump_q) begin
      mode_d = MODE_WATER;
      if (ge) begin
        elapsed_d = '0;
        pump_d    = 1'b0;
        soaks_d   = soaks_dec;
        if (soaks_dec != 4'd0) begin
          mode_d = MODE_SOAK;
        end else begin
          cool_d = 1'b1;
          mode_d = MODE_COOL;
        end
      end
      if (all_fault_q) mode_d = MODE_FAULT;
    end else if (soaks_q != 4'd0) begin
      mode_d = MODE_SOAK;
      if (ge) begin
        elapsed_d = '0;
        pump_d    = 1'b1;
        mode_d    = MODE_WATER;
      end
      if (all_fault_q) mode_d = MODE_FAULT;
    end else if (cool_q) begin
      mode_d = MODE_COOL;
      if (ge) begin
        elapsed_d = '0;
        cool_d    = 1'b0;
        mode_d    = MODE_MONITOR;
      end
      if (all_fault_q) mode_d = MODE_FAULT;
    end else begin
      mode_d = all_fault_q ? MODE_FAULT : MODE_MONITOR;
      if (any_dry_q) begin
        elapsed_d = '0;
        soaks_d   = soaks_eff;
        pump_d    = 1'b1;
        mode_d    = MODE_WATER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 4'd0;
      per_plant_q <= 16'd1000;
      base_q      <= 16'd1000;
      soak_cyc_q  <= 4'd3;
      soak_ms_q   <= 24'd30000;
      cool_ms_q   <= 24'd60000;
      tick_ms_q   <= 16'd1000;
      state_q     <= ST_IDLE;
      pump_q      <= 1'b0;
      soaks_q     <= 4'd0;
      cool_q      <= 1'b0;
      elapsed_q   <= '0;
      all_fault_q <= 1'b0;
      any_dry_q   <= 1'b0;
      dry_q       <= '0;
      pulse_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_MONITOR;
      pump_out_q  <= 1'b0;
      needs_q     <= '0;
      pulses_q    <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_idx)
          REG_ACTIVE:    active_q    <= pwdata[3:0];
          REG_PER_PLANT: per_plant_q <= pwdata[15:0];
          REG_BASE:      base_q      <= pwdata[15:0];
          REG_SOAK_CYC:  soak_cyc_q  <= pwdata[3:0];
          REG_SOAK_MS:   soak_ms_q   <= pwdata[23:0];
          REG_COOL_MS:   cool_ms_q   <= pwdata[23:0];
          REG_TICK_MS:   tick_ms_q   <= pwdata[15:0];
          default:       ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != ST_UPD) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dry_q       <= dry_flags_i & mask8;
            any_dry_q   <= (dry_flags_i & mask8) != 8'd0;
            all_fault_q <= (n_eff != 4'd0) && (n_eff <= 4'd8) &&
                           ((fault_flags_i & mask8) == mask8);
            elapsed_q   <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            pulse_q <= div_rsp.quotient;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (!out_valid_q || !out_stall_i) begin
            pump_q      <= pump_d;
            soaks_q     <= soaks_d;
            cool_q      <= cool_d;
            elapsed_q   <= elapsed_d;
            mode_q      <= mode_d;
            pump_out_q  <= pump_d;
            needs_q     <= dry_q;
            pulses_q    <= soaks_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign display_mode_o = mode_q;
  assign pump_on_o      = pump_out_q;
  assign needs_water_o  = needs_q;
  assign pulses_left_o  = pulses_q;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the pulsed irrigation sequencer: predicts every result beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pis_pkg::*;

  localparam int unsigned PLANTS         = 8;
  localparam int unsigned TOTAL_TICKS    = 1850;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] dry;
    logic [7:0] fault;
  } tick_in_t;

  typedef struct packed {
    mode_e      mode;
    logic       pump;
    logic [7:0] needs;
    logic [3:0] left;
  } tick_out_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  dry_flags_i   = '0;
  logic [7:0]  fault_flags_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  display_mode_o;
  logic        pump_on_o;
  logic [7:0]  needs_water_o;
  logic [3:0]  pulses_left_o;

  logic [3:0]  plants_cfg     = 4'd0;
  logic [15:0] per_plant_cfg  = 16'd1000;
  logic [15:0] base_cfg       = 16'd1000;
  logic [3:0]  soak_count_cfg = 4'd3;
  logic [23:0] soak_ms_cfg    = 24'd30000;
  logic [23:0] cool_ms_cfg    = 24'd60000;
  logic [15:0] tick_ms_cfg    = 16'd1000;

  logic        pump_is_on   = 1'b0;
  logic [3:0]  pulses_to_go = 4'd0;
  logic        in_cooldown  = 1'b0;
  logic [31:0] timer_ms     = '0;

  tick_in_t    queued_ticks[$];
  tick_out_t   predicted_outputs[$];
  int unsigned ticks_sent = 0;
  int unsigned errors = 0;
  logic        calm_phase = 1'b0;

  pulsed_irrigation_sequencer_top #(.MAX_PLANTS(PLANTS)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_phase || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 120);
  endfunction

  function automatic tick_out_t advance_sequencer(logic [7:0] dry, logic [7:0] fault);
    logic [3:0]  plants;
    logic [7:0]  in_use;
    logic [7:0]  thirsty;
    logic        all_faulted;
    logic [3:0]  pulses;
    logic [31:0] pulse_ms;
    logic [32:0] sum;
    mode_e       mode;
    tick_out_t   res;
    plants = (plants_cfg > PLANTS) ? 4'(PLANTS) : plants_cfg;
    in_use = 8'((9'd1 << plants) - 9'd1);
    thirsty = dry & in_use;
    all_faulted = (plants != 0) && ((fault & in_use) == in_use);
    pulses = (soak_count_cfg == 0) ? 4'd1 : soak_count_cfg;
    pulse_ms = (32'(per_plant_cfg) * 32'(plants) + 32'(base_cfg)) / 32'(pulses);
    sum = 33'(timer_ms) + 33'(tick_ms_cfg);
    timer_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (pump_is_on) begin
      mode = MODE_WATER;
      if (timer_ms >= pulse_ms) begin
        timer_ms = '0;
        pump_is_on = 1'b0;
        if (pulses_to_go != 0) pulses_to_go = pulses_to_go - 4'd1;
        if (pulses_to_go != 0) begin
          mode = MODE_SOAK;
        end else begin
          in_cooldown = 1'b1;
          mode = MODE_COOL;
        end
      end
      if (all_faulted) mode = MODE_FAULT;
    end else if (pulses_to_go != 0) begin
      mode = MODE_SOAK;
      if (timer_ms >= 32'(soak_ms_cfg)) begin
        timer_ms = '0;
        pump_is_on = 1'b1;
        mode = MODE_WATER;
      end
      if (all_faulted) mode = MODE_FAULT;
    end else if (in_cooldown) begin
      mode = MODE_COOL;
      if (timer_ms >= 32'(cool_ms_cfg)) begin
        timer_ms = '0;
        in_cooldown = 1'b0;
        mode = MODE_MONITOR;
      end
      if (all_faulted) mode = MODE_FAULT;
    end else begin
      if (all_faulted) mode = MODE_FAULT;
      else mode = MODE_MONITOR;
      if (thirsty != 0) begin
        timer_ms = '0;
        pulses_to_go = pulses;
        pump_is_on = 1'b1;
        mode = MODE_WATER;
      end
    end
    res.mode = mode;
    res.pump = pump_is_on;
    res.needs = thirsty;
    res.left = pulses_to_go;
    return res;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic void queue_tick(logic [7:0] dry, logic [7:0] fault);
    tick_in_t t;
    t.dry = dry;
    t.fault = fault;
    queued_ticks.push_back(t);
    ticks_sent++;
  endfunction

  task automatic apb_write(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE:    plants_cfg = value[3:0];
      REG_PER_PLANT: per_plant_cfg = value[15:0];
      REG_BASE:      base_cfg = value[15:0];
      REG_SOAK_CYC:  soak_count_cfg = value[3:0];
      REG_SOAK_MS:   soak_ms_cfg = value[23:0];
      REG_COOL_MS:   cool_ms_cfg = value[23:0];
      REG_TICK_MS:   tick_ms_cfg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_sequencer(int unsigned plants, int unsigned per_plant, int unsigned base,
                                   int unsigned soaks, int unsigned soak_ms, int unsigned cool_ms,
                                   int unsigned tick_ms);
    apb_write(REG_ACTIVE, plants);
    apb_write(REG_PER_PLANT, per_plant);
    apb_write(REG_BASE, base);
    apb_write(REG_SOAK_CYC, soaks);
    apb_write(REG_SOAK_MS, soak_ms);
    apb_write(REG_COOL_MS, cool_ms);
    apb_write(REG_TICK_MS, tick_ms);
  endtask

  task automatic drain();
    while (queued_ticks.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap_left;
    tick_in_t    next;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      dry_flags_i <= '0;
      fault_flags_i <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_outputs.push_back(advance_sequencer(dry_flags_i, fault_flags_i));
        gap_left = pick_pause();
      end
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (queued_ticks.size() != 0) begin
        next = queued_ticks.pop_front();
        dry_flags_i <= next.dry;
        fault_flags_i <= next.fault;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_left;
    tick_out_t   want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_outputs.size() == 0) begin
          flag_error($sformatf("%0t unexpected beat: mode %0d pump %0b needs %02h left %0d",
                               $time, display_mode_o, pump_on_o, needs_water_o, pulses_left_o));
        end else begin
          want = predicted_outputs.pop_front();
          if (display_mode_o !== want.mode || pump_on_o !== want.pump ||
              needs_water_o !== want.needs || pulses_left_o !== want.left)
            flag_error($sformatf(
              "%0t mismatch exp/act: mode %0d/%0d pump %0b/%0b needs %02h/%02h left %0d/%0d",
              $time, want.mode, display_mode_o, want.pump, pump_on_o,
              want.needs, needs_water_o, want.left, pulses_left_o));
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_pause();
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned roll;
    int unsigned span;
    int unsigned tick;
    logic [7:0]  in_use;
    logic [7:0]  dry;
    logic [7:0]  fault;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_tick(8'hFF, 8'hFF);
    queue_tick(8'h00, 8'h00);
    drain();

    program_sequencer(3, 1000, 1000, 2, 2000, 2000, 1000);
    queue_tick(8'h00, 8'h07);
    queue_tick(8'hF8, 8'h00);
    queue_tick(8'h01, 8'h07);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h07);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h03);
    drain();

    program_sequencer(15, 16'hFFFF, 16'hFFFF, 0, 0, 0, 16'hFFFF);
    queue_tick(8'h80, 8'h7F);
    queue_tick(8'h00, 8'hFF);
    queue_tick(8'hFF, 8'h00);
    queue_tick(8'h55, 8'hAA);
    queue_tick(8'hAA, 8'h55);
    queue_tick(8'h00, 8'hFF);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'h00);
    queue_tick(8'h00, 8'hFF);
    drain();

    phase = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      case (phase % 5)
        0: program_sequencer($urandom_range(1, 8), 0, 0, 0, 0, 0, 1);
        1: program_sequencer(15, 16'hFFFF, 16'hFFFF, 15, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
        default: begin
          roll = $urandom_range(0, 99);
          tick = (roll < 3) ? 0 : $urandom_range(1, 3000);
          roll = $urandom_range(0, 99);
          if (roll < 10) span = $urandom_range(9, 15);
          else if (roll < 18) span = 0;
          else span = $urandom_range(1, 8);
          program_sequencer(span, $urandom_range(0, 2 * tick + 1), $urandom_range(0, 4 * tick + 1),
                            $urandom_range(0, 15), $urandom_range(0, 4 * tick + 1),
                            $urandom_range(0, 5 * tick + 1), tick);
        end
      endcase
      calm_phase = ($urandom_range(0, 4) == 0);
      span = (plants_cfg > PLANTS) ? PLANTS : plants_cfg;
      in_use = 8'((9'd1 << span) - 9'd1);
      count = $urandom_range(30, 100);
      repeat (count) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) dry = 8'h00;
        else if (roll < 45) dry = 8'($urandom) & ~in_use;
        else dry = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30) fault = 8'h00;
        else if (roll < 55) fault = 8'($urandom) | in_use;
        else fault = 8'($urandom);
        queue_tick(dry, fault);
      end
      drain();
      phase++;
    end

    if (predicted_outputs.size() != 0)
      flag_error($sformatf("%0d result beats never arrived", predicted_outputs.size()));
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pis_pkg.sv
hdl/pis_div.sv
hdl/pulsed_irrigation_sequencer_top.sv
dv/testbench.sv
